@@ hw/rtl/svlm_pkg.sv @@
// shared types, codes and threshold tables for the supply voltage level monitor
package svlm_pkg;

    // item kinds carried in the mode field
    localparam logic [1:0] MODE_SAMPLE = 2'd0;
    localparam logic [1:0] MODE_LEVEL  = 2'd1;
    localparam logic [1:0] MODE_INTCTL = 2'd2;
    localparam logic [1:0] MODE_FLAGS  = 2'd3;

    // configuration register indexes
    localparam logic CFG_LEVEL_CODE  = 1'b0;
    localparam logic CFG_ACTIVE_MODE = 1'b1;

    // field widths
    localparam int unsigned MODE_W   = 2;
    localparam int unsigned SUPPLY_W = 16;
    localparam int unsigned WDATA_W  = 8;
    localparam int unsigned LEVEL_W  = 3;
    localparam int unsigned ACTIVE_W = 2;
    localparam int unsigned CFG_W    = 3;
    localparam int unsigned IN_W     = 24;
    localparam int unsigned OUT_W    = 8;
    // thresholds top out at 5250 mV
    localparam int unsigned MV_W     = 13;

    // level codes with their own base level, every other code is the lowest
    localparam logic [LEVEL_W-1:0] LVL_2600 = 3'd2;
    localparam logic [LEVEL_W-1:0] LVL_4200 = 3'd7;

    // margin codes, the reserved code falls back to the smallest margin
    localparam logic [1:0] MARGIN_15 = 2'd1;
    localparam logic [1:0] MARGIN_25 = 2'd2;

    // edge selection codes
    localparam logic [1:0] EDGE_BELOW = 2'd0;
    localparam logic [1:0] EDGE_ABOVE = 2'd1;
    localparam logic [1:0] EDGE_BOTH  = 2'd2;

    localparam int unsigned BASE_LO  = 1800;
    localparam int unsigned BASE_MID = 2600;
    localparam int unsigned BASE_HI  = 4200;
    localparam int unsigned PCT_5    = 5;
    localparam int unsigned PCT_15   = 15;
    localparam int unsigned PCT_25   = 25;

    localparam int unsigned SUPPLY_RESET = 3300;

    // margin thresholds, worked out at elaboration
    localparam int unsigned MON_LO_5   = BASE_LO * (100 + PCT_5) / 100;
    localparam int unsigned MON_LO_15  = BASE_LO * (100 + PCT_15) / 100;
    localparam int unsigned MON_LO_25  = BASE_LO * (100 + PCT_25) / 100;
    localparam int unsigned MON_MID_5  = BASE_MID * (100 + PCT_5) / 100;
    localparam int unsigned MON_MID_15 = BASE_MID * (100 + PCT_15) / 100;
    localparam int unsigned MON_MID_25 = BASE_MID * (100 + PCT_25) / 100;
    localparam int unsigned MON_HI_5   = BASE_HI * (100 + PCT_5) / 100;
    localparam int unsigned MON_HI_15  = BASE_HI * (100 + PCT_15) / 100;
    localparam int unsigned MON_HI_25  = BASE_HI * (100 + PCT_25) / 100;

    // one input item
    typedef struct packed {
        logic [WDATA_W-1:0]  write_data;
        logic [SUPPLY_W-1:0] supply_mv;
        logic [MODE_W-1:0]   mode;
    } svlm_item_t;

    // fuse-loaded settings
    typedef struct packed {
        logic [ACTIVE_W-1:0] active_mode;
        logic [LEVEL_W-1:0]  level_code;
    } svlm_cfg_t;

    // one result item, last field in the lowest bit
    typedef struct packed {
        logic brownout_event;
        logic irq_clear;
        logic irq_raise;
        logic level_flag;
        logic below_status;
    } svlm_result_t;

    // base detector level in mV
    function automatic logic [MV_W-1:0] base_mv(input logic [LEVEL_W-1:0] code);
        logic [MV_W-1:0] mv;
        case (code)
            LVL_2600: mv = MV_W'(BASE_MID);
            LVL_4200: mv = MV_W'(BASE_HI);
            default:  mv = MV_W'(BASE_LO);
        endcase
        return mv;
    endfunction

    // monitor threshold in mV: base level raised by the selected margin
    function automatic logic [MV_W-1:0] monitor_mv(input logic [LEVEL_W-1:0] code,
                                                   input logic [1:0] margin);
        logic [MV_W-1:0] mv;
        case (code)
            LVL_2600: begin
                case (margin)
                    MARGIN_15: mv = MV_W'(MON_MID_15);
                    MARGIN_25: mv = MV_W'(MON_MID_25);
                    default:   mv = MV_W'(MON_MID_5);
                endcase
            end
            LVL_4200: begin
                case (margin)
                    MARGIN_15: mv = MV_W'(MON_HI_15);
                    MARGIN_25: mv = MV_W'(MON_HI_25);
                    default:   mv = MV_W'(MON_HI_5);
                endcase
            end
            default: begin
                case (margin)
                    MARGIN_15: mv = MV_W'(MON_LO_15);
                    MARGIN_25: mv = MV_W'(MON_LO_25);
                    default:   mv = MV_W'(MON_LO_5);
                endcase
            end
        endcase
        return mv;
    endfunction

endpackage

@@ hw/rtl/svlm_core.sv @@
// monitor state, threshold compare and flag/interrupt update for one item
module svlm_core (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 adv,
    input  svlm_pkg::svlm_item_t item,
    input  svlm_pkg::svlm_cfg_t  cfg,
    output svlm_pkg::svlm_result_t res
);
    import svlm_pkg::*;

    logic [SUPPLY_W-1:0] supply_reg, supply_next;
    logic [1:0]          margin_reg, margin_next;
    logic [1:0]          edge_cfg_reg, edge_cfg_next;
    logic                irq_en_reg, irq_en_next;
    logic                flag_reg, flag_next;
    logic                status_reg, status_next;
    logic                was_below_reg, was_below_next;
    logic                was_bor_reg, was_bor_next;

    logic                active;
    logic                evaluate;
    logic [MV_W-1:0]     thr_mv;
    logic [MV_W-1:0]     bor_mv;
    logic                below;
    logic                bor;
    logic                trig;
    logic                raise;
    logic                clear;
    logic                bo;

    assign active = cfg.active_mode != '0;

    // supply and level writes re-evaluate against the new values
    always_comb begin
        supply_next   = supply_reg;
        margin_next   = margin_reg;
        edge_cfg_next = edge_cfg_reg;
        irq_en_next   = irq_en_reg;
        evaluate      = 1'b0;
        case (item.mode)
            MODE_SAMPLE: begin
                supply_next = item.supply_mv;
                evaluate    = 1'b1;
            end
            MODE_LEVEL: begin
                margin_next = item.write_data[1:0];
                evaluate    = 1'b1;
            end
            MODE_INTCTL: begin
                irq_en_next   = item.write_data[0];
                edge_cfg_next = item.write_data[2:1];
            end
            default: ;
        endcase
    end

    // threshold compares
    assign thr_mv = monitor_mv(cfg.level_code, margin_next);
    assign bor_mv = base_mv(cfg.level_code);
    assign below  = supply_next < {{(SUPPLY_W-MV_W){1'b0}}, thr_mv};
    assign bor    = supply_next < {{(SUPPLY_W-MV_W){1'b0}}, bor_mv};

    // crossing in the configured direction
    always_comb begin
        case (edge_cfg_reg)
            EDGE_BELOW: trig = below;
            EDGE_ABOVE: trig = !below;
            EDGE_BOTH:  trig = 1'b1;
            default:    trig = 1'b0;
        endcase
    end

    // status, flag and pulse update
    always_comb begin
        status_next    = status_reg;
        flag_next      = flag_reg;
        was_below_next = was_below_reg;
        was_bor_next   = was_bor_reg;
        raise          = 1'b0;
        clear          = 1'b0;
        bo             = 1'b0;
        if (evaluate) begin
            if (active) begin
                status_next = below;
                if (below != was_below_reg && trig) begin
                    flag_next = 1'b1;
                    raise     = irq_en_reg;
                end
            end
            was_below_next = below;
            bo             = active && bor && !was_bor_reg;
            was_bor_next   = bor;
        end else if (item.mode == MODE_INTCTL) begin
            raise = irq_en_next && flag_reg;
        end else if (item.mode == MODE_FLAGS) begin
            if (item.write_data[0]) begin
                flag_next = 1'b0;
            end
            clear = !flag_next;
        end
    end

    assign res.below_status   = status_next;
    assign res.level_flag     = flag_next;
    assign res.irq_raise      = raise;
    assign res.irq_clear      = clear;
    assign res.brownout_event = bo;

    // state registers, updated once per item
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            supply_reg    <= SUPPLY_W'(SUPPLY_RESET);
            margin_reg    <= '0;
            edge_cfg_reg  <= '0;
            irq_en_reg    <= 1'b0;
            flag_reg      <= 1'b0;
            status_reg    <= 1'b0;
            was_below_reg <= 1'b0;
            was_bor_reg   <= 1'b0;
        end else if (adv) begin
            supply_reg    <= supply_next;
            margin_reg    <= margin_next;
            edge_cfg_reg  <= edge_cfg_next;
            irq_en_reg    <= irq_en_next;
            flag_reg      <= flag_next;
            status_reg    <= status_next;
            was_below_reg <= was_below_next;
            was_bor_reg   <= was_bor_next;
        end
    end

    // raise and clear pulses never come from the same item
    a_raise_clear_excl: assert property (@(posedge aclk) disable iff (!aresetn)
        !(res.irq_raise && res.irq_clear))
        else $error("raise and clear pulses together");

    // brown-out events only while the detector is active
    a_bo_active: assert property (@(posedge aclk) disable iff (!aresetn)
        res.brownout_event |-> active)
        else $error("brown-out event while detector inactive");

    // a write-one-to-clear leaves the flag clear
    a_flag_clear: assert property (@(posedge aclk) disable iff (!aresetn)
        (adv && item.mode == MODE_FLAGS && item.write_data[0]) |=> !flag_reg)
        else $error("flag not cleared by flags write");

    // state only moves when an item is processed
    a_state_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        !adv |=> $stable(flag_reg) && $stable(status_reg) && $stable(supply_reg))
        else $error("state changed without an item");

endmodule

@@ hw/rtl/supply_voltage_level_monitor.sv @@
// top level: input register, monitor core, result register and configuration
//
// Supply voltage level monitor with brown-out detection. Each input transfer is
// either a supply sample in mV or a write to the level-select, interrupt-control
// or flags register; each produces exactly one result transfer carrying the below
// status, the sticky flag and the raise, clear and brown-out pulses. An item
// passes an input register, then the threshold table lookup, compare and flag
// update, then the result register; one item is accepted every cycle while the
// result side keeps taking transfers. The fuse-loaded level code and active mode
// must be written over the cfg port only while the block is idle; the block
// itself does not enforce this.
module supply_voltage_level_monitor (
    input  logic                         aclk,
    input  logic                         aresetn,
    // configuration write port
    input  logic                         cfg_we,
    input  logic                         cfg_addr,
    input  logic [svlm_pkg::CFG_W-1:0]   cfg_wdata,
    // input items
    input  logic                         s_tvalid,
    output logic                         s_tready,
    // [1:0] mode
    input  logic [svlm_pkg::MODE_W-1:0]  s_tuser,
    // [15:0] supply_mv, [23:16] write_data
    input  logic [svlm_pkg::IN_W-1:0]    s_tdata,
    // result items
    output logic                         m_tvalid,
    input  logic                         m_tready,
    // [0] below_status, [1] level_flag, [2] irq_raise, [3] irq_clear,
    // [4] brownout_event, [7:5] zero
    output logic [svlm_pkg::OUT_W-1:0]   m_tdata
);
    import svlm_pkg::*;

    localparam int unsigned RES_W  = $bits(svlm_result_t);

    svlm_cfg_t    cfg_reg;
    logic         in_valid_reg;
    svlm_item_t   in_item_reg;
    logic         out_valid_reg;
    svlm_result_t out_res_reg;
    svlm_result_t res;
    logic         adv;

    // item moves on when the result register is free or being emptied
    assign adv      = in_valid_reg && (!out_valid_reg || m_tready);
    assign s_tready = !in_valid_reg || adv;

    // configuration registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg <= '0;
        end else if (cfg_we) begin
            unique case (cfg_addr)
                CFG_LEVEL_CODE:  cfg_reg.level_code  <= cfg_wdata[LEVEL_W-1:0];
                CFG_ACTIVE_MODE: cfg_reg.active_mode <= cfg_wdata[ACTIVE_W-1:0];
                default: ;
            endcase
        end
    end

    // input register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_tready) begin
            in_valid_reg <= s_tvalid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_tvalid && s_tready) begin
            in_item_reg <= svlm_item_t'({s_tdata, s_tuser});
        end
    end

    svlm_core u_core (
        .aclk    (aclk),
        .aresetn (aresetn),
        .adv     (adv),
        .item    (in_item_reg),
        .cfg     (cfg_reg),
        .res     (res)
    );

    // result register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (adv) begin
            out_valid_reg <= 1'b1;
        end else if (m_tready) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            out_res_reg <= res;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {{(OUT_W-RES_W){1'b0}}, out_res_reg};

    // a waiting result holds until taken
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && !m_tready) |=> m_tvalid && $stable(m_tdata))
        else $error("result dropped or changed while stalled");

    // an item in the input register is never lost
    a_in_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        (in_valid_reg && !adv) |=> in_valid_reg)
        else $error("pending item lost");

    // every advanced item shows up as a result
    a_adv_out: assert property (@(posedge aclk) disable iff (!aresetn)
        adv |=> m_tvalid)
        else $error("advanced item produced no result");

endmodule

@@ sim/tb_top.sv @@
// testbench for the supply voltage level monitor: directed and random streams, result scoreboard
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    import svlm_pkg::*;

    localparam int unsigned QUIET_LIMIT  = 2000;
    localparam int unsigned PHASE_COUNT  = 8;
    localparam int unsigned PHASE_ITEMS  = 172;

    logic                aclk      = 1'b0;
    logic                aresetn   = 1'b0;
    logic                cfg_we    = 1'b0;
    logic                cfg_addr  = CFG_LEVEL_CODE;
    logic [CFG_W-1:0]    cfg_wdata = '0;
    logic                s_tvalid  = 1'b0;
    logic                s_tready;
    logic [MODE_W-1:0]   s_tuser   = '0;
    logic [IN_W-1:0]     s_tdata   = '0;
    logic                m_tvalid;
    logic                m_tready  = 1'b0;
    logic [OUT_W-1:0]    m_tdata;

    // expected view of the monitor, updated at each accepted input transfer
    logic [LEVEL_W-1:0]  lvl_code    = '0;
    logic [ACTIVE_W-1:0] act_mode    = '0;
    logic [SUPPLY_W-1:0] supply_now  = SUPPLY_W'(SUPPLY_RESET);
    logic [1:0]          margin_sel  = '0;
    logic [1:0]          edge_sel    = '0;
    logic                irq_en      = 1'b0;
    logic                flag_q      = 1'b0;
    logic                status_q    = 1'b0;
    logic                below_q     = 1'b0;
    logic                brownout_q  = 1'b0;

    svlm_result_t        pending_results[$];
    int unsigned         fail_count  = 0;
    bit                  src_idle    = 1'b1;
    bit                  sink_idle   = 1'b1;

    supply_voltage_level_monitor u_top (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_we    (cfg_we),
        .cfg_addr  (cfg_addr),
        .cfg_wdata (cfg_wdata),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tuser   (s_tuser),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata)
    );

    always #5 aclk = ~aclk;

    // base detector level in mV
    function automatic int unsigned floor_mv(input logic [LEVEL_W-1:0] code);
        int unsigned mv;
        case (code)
            LVL_2600: mv = BASE_MID;
            LVL_4200: mv = BASE_HI;
            default:  mv = BASE_LO;
        endcase
        return mv;
    endfunction

    // base level plus percentage margin
    function automatic int unsigned trip_mv(input logic [LEVEL_W-1:0] code,
                                            input logic [1:0] margin);
        int unsigned pct;
        case (margin)
            MARGIN_15: pct = PCT_15;
            MARGIN_25: pct = PCT_25;
            default:   pct = PCT_5;
        endcase
        return floor_mv(code) * (100 + pct) / 100;
    endfunction

    // compare the held supply; bit 0 is the raise pulse, bit 1 the brown-out pulse
    function automatic logic [1:0] reevaluate();
        logic [1:0] pulses;
        logic       below;
        logic       bor;
        logic       hit;
        pulses = '0;
        below  = supply_now < trip_mv(lvl_code, margin_sel);
        bor    = supply_now < floor_mv(lvl_code);
        if (act_mode != '0) begin
            status_q = below;
            if (below != below_q) begin
                case (edge_sel)
                    EDGE_BELOW: hit = below;
                    EDGE_ABOVE: hit = !below;
                    EDGE_BOTH:  hit = 1'b1;
                    default:    hit = 1'b0;
                endcase
                if (hit) begin
                    flag_q = 1'b1;
                    if (irq_en) begin
                        pulses[0] = 1'b1;
                    end
                end
            end
            if (bor && !brownout_q) begin
                pulses[1] = 1'b1;
            end
        end
        // the compare history follows the supply even while inactive
        below_q    = below;
        brownout_q = bor;
        return pulses;
    endfunction

    // expected result of one item
    function automatic svlm_result_t next_result(input svlm_item_t it);
        svlm_result_t r;
        logic [1:0]   p;
        r = '0;
        case (it.mode)
            MODE_SAMPLE: begin
                supply_now       = it.supply_mv;
                p                = reevaluate();
                r.irq_raise      = p[0];
                r.brownout_event = p[1];
            end
            MODE_LEVEL: begin
                margin_sel       = it.write_data[1:0];
                p                = reevaluate();
                r.irq_raise      = p[0];
                r.brownout_event = p[1];
            end
            MODE_INTCTL: begin
                irq_en      = it.write_data[0];
                edge_sel    = it.write_data[2:1];
                r.irq_raise = irq_en && flag_q;
            end
            default: begin
                if (it.write_data[0]) begin
                    flag_q = 1'b0;
                end
                r.irq_clear = !flag_q;
            end
        endcase
        r.below_status = status_q;
        r.level_flag   = flag_q;
        return r;
    endfunction

    function automatic svlm_item_t make_item(input logic [MODE_W-1:0] mode,
                                             input logic [SUPPLY_W-1:0] mv,
                                             input logic [WDATA_W-1:0] wd);
        svlm_item_t it;
        it.mode       = mode;
        it.supply_mv  = mv;
        it.write_data = wd;
        return it;
    endfunction

    // mostly samples close to a threshold, with register writes mixed in
    function automatic svlm_item_t random_item();
        svlm_item_t  it;
        int unsigned pick;
        int unsigned near;
        it.supply_mv  = SUPPLY_W'($urandom_range(0, 65535));
        it.write_data = WDATA_W'($urandom_range(0, 255));
        pick = $urandom_range(0, 99);
        if (pick < 55) begin
            it.mode = MODE_SAMPLE;
            if ($urandom_range(0, 4) != 0) begin
                if ($urandom_range(0, 1) != 0) begin
                    near = trip_mv(lvl_code, 2'($urandom_range(0, 3)));
                end else begin
                    near = floor_mv(lvl_code);
                end
                it.supply_mv = SUPPLY_W'(near + $urandom_range(0, 16) - 8);
            end
        end else if (pick < 68) begin
            it.mode = MODE_LEVEL;
        end else if (pick < 82) begin
            it.mode = MODE_INTCTL;
        end else begin
            it.mode = MODE_FLAGS;
        end
        return it;
    endfunction

    function automatic void check_field(input string name, input logic want, input logic got);
        if (got !== want) begin
            $error("%s mismatch: expected %b, got %b", name, want, got);
            fail_count++;
        end
    endfunction

    // one input transfer, called and left at a falling edge
    task automatic send_item(input svlm_item_t it);
        int unsigned gap;
        gap = src_idle ? $urandom_range(0, 15) : 0;
        if (gap != 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(negedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= it.mode;
        s_tdata  <= {it.write_data, it.supply_mv};
        do @(posedge aclk); while (!s_tready);
        pending_results.push_back(next_result(it));
        @(negedge aclk);
    endtask

    // stop sending and wait for every outstanding result
    task automatic drain();
        s_tvalid <= 1'b0;
        while (pending_results.size() != 0) @(posedge aclk);
        repeat (4) @(negedge aclk);
    endtask

    task automatic write_cfg(input logic addr, input logic [CFG_W-1:0] data);
        cfg_we    <= 1'b1;
        cfg_addr  <= addr;
        cfg_wdata <= data;
        @(posedge aclk);
        if (addr == CFG_LEVEL_CODE) begin
            lvl_code = data;
        end else begin
            act_mode = data[ACTIVE_W-1:0];
        end
        @(negedge aclk);
    endtask

    // fuse settings change only with the block idle
    task automatic set_config(input logic [LEVEL_W-1:0] level, input logic [ACTIVE_W-1:0] active);
        drain();
        write_cfg(CFG_LEVEL_CODE, level);
        write_cfg(CFG_ACTIVE_MODE, CFG_W'(active));
        cfg_we <= 1'b0;
    endtask

    // detector off after reset: status stays, compare history still follows the supply
    task automatic test_inactive_tracking();
        send_item(make_item(MODE_SAMPLE, 16'd1000, 8'h00));
        send_item(make_item(MODE_FLAGS, 16'd0, 8'h00));
        set_config(3'd0, 2'd1);
        // no false edge once enabled
        send_item(make_item(MODE_SAMPLE, 16'd1000, 8'h00));
    endtask

    // threshold edges, edge selections, flag clearing and margin changes at the lowest level
    task automatic test_threshold_edges();
        send_item(make_item(MODE_INTCTL, 16'd0, {5'd0, EDGE_ABOVE, 1'b1}));
        send_item(make_item(MODE_SAMPLE, 16'd1890, 8'h00));
        send_item(make_item(MODE_SAMPLE, 16'd1889, 8'h00));
        send_item(make_item(MODE_FLAGS, 16'd0, 8'hfe));
        send_item(make_item(MODE_FLAGS, 16'd0, 8'h01));
        send_item(make_item(MODE_INTCTL, 16'd0, {5'd0, EDGE_BELOW, 1'b1}));
        send_item(make_item(MODE_SAMPLE, 16'd1799, 8'h00));
        send_item(make_item(MODE_SAMPLE, 16'd65535, 8'h00));
        send_item(make_item(MODE_SAMPLE, 16'd0, 8'h00));
        // enabling with the flag already set raises at once
        send_item(make_item(MODE_INTCTL, 16'd0, {5'd0, EDGE_BOTH, 1'b0}));
        send_item(make_item(MODE_INTCTL, 16'd0, {5'd0, EDGE_BOTH, 1'b1}));
        send_item(make_item(MODE_FLAGS, 16'd0, 8'hff));
        send_item(make_item(MODE_SAMPLE, 16'd2000, 8'h00));
        send_item(make_item(MODE_FLAGS, 16'd0, 8'h01));
        // level-select writes re-evaluate the held supply; reserved margin is the smallest
        send_item(make_item(MODE_LEVEL, 16'd0, {6'h3f, MARGIN_25}));
        send_item(make_item(MODE_LEVEL, 16'd0, 8'h03));
        send_item(make_item(MODE_LEVEL, 16'd0, {6'd0, MARGIN_15}));
        // reserved edge selection never sets the flag
        send_item(make_item(MODE_INTCTL, 16'd0, 8'h07));
        send_item(make_item(MODE_FLAGS, 16'd0, 8'h01));
        send_item(make_item(MODE_SAMPLE, 16'd65535, 8'h00));
    endtask

    // the other level codes, a reserved one among them
    task automatic test_level_codes();
        set_config(LVL_4200, 2'd3);
        send_item(make_item(MODE_SAMPLE, 16'd4829, 8'h00));
        send_item(make_item(MODE_SAMPLE, 16'd4199, 8'h00));
        set_config(LVL_2600, 2'd2);
        send_item(make_item(MODE_INTCTL, 16'd0, {5'd0, EDGE_ABOVE, 1'b1}));
        send_item(make_item(MODE_SAMPLE, 16'd2600, 8'h00));
        send_item(make_item(MODE_SAMPLE, 16'd2599, 8'h00));
        set_config(3'd5, 2'd1);
        send_item(make_item(MODE_SAMPLE, 16'd1850, 8'h00));
    endtask

    // random phases, each with its own fuse settings and idling pattern
    task automatic test_random_phases();
        logic [LEVEL_W-1:0]  level;
        logic [ACTIVE_W-1:0] active;
        for (int unsigned ph = 0; ph < PHASE_COUNT; ph++) begin
            level  = (ph == 0) ? LVL_4200 : (ph == 1) ? 3'd0 : LEVEL_W'($urandom_range(0, 7));
            active = (ph == 1) ? 2'd0 : (ph == 2) ? 2'd3 : ACTIVE_W'($urandom_range(0, 3));
            set_config(level, active);
            src_idle  = (ph % 4 == 0) || (ph % 4 == 2);
            sink_idle = (ph % 4 == 0) || (ph % 4 == 3);
            repeat (PHASE_ITEMS) send_item(random_item());
        end
        src_idle  = 1'b1;
        sink_idle = 1'b1;
    endtask

    // result side: random back-pressure and in-order comparison
    initial begin
        int unsigned  stall;
        svlm_result_t got;
        svlm_result_t want;
        @(posedge aresetn);
        forever begin
            stall = sink_idle ? $urandom_range(0, 15) : 0;
            if (stall != 0) begin
                m_tready <= 1'b0;
                repeat (stall) @(negedge aclk);
            end
            m_tready <= 1'b1;
            do @(posedge aclk); while (!m_tvalid);
            got = svlm_result_t'(m_tdata[4:0]);
            if (pending_results.size() == 0) begin
                $error("result transfer with nothing outstanding: %b", got);
                fail_count++;
            end else begin
                want = pending_results.pop_front();
                check_field("below_status", want.below_status, got.below_status);
                check_field("level_flag", want.level_flag, got.level_flag);
                check_field("irq_raise", want.irq_raise, got.irq_raise);
                check_field("irq_clear", want.irq_clear, got.irq_clear);
                check_field("brownout_event", want.brownout_event, got.brownout_event);
            end
            @(negedge aclk);
        end
    end

    // watchdog on cycles without any transfer
    int unsigned quiet_cycles = 0;
    always @(posedge aclk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
            quiet_cycles = 0;
        end else begin
            quiet_cycles++;
        end
        if (quiet_cycles >= QUIET_LIMIT) begin
            $display("Verification failed");
            $finish;
        end
    end

    // test sequence
    initial begin
        repeat (6) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;
        test_inactive_tracking();
        test_threshold_edges();
        test_level_codes();
        test_random_phases();
        drain();
        repeat (10) @(posedge aclk);
        if (pending_results.size() != 0) begin
            $error("%0d results never arrived", pending_results.size());
            fail_count++;
        end
        if (fail_count == 0) begin
            $display("Verification passed");
        end else begin
            $display("Verification failed");
        end
        $finish;
    end

endmodule
